>>> design/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define ASSERT_CLKD(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen on a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
  `ASSERT_CLKD(label, clk, rstn, !(cond), msg)

`endif

>>> design/ipd_pkg.sv
// Package for the indexed icon pixel decoder: constants, shared types and
// the 5-bit to 8-bit channel expansion table. No dependencies.
package ipd_pkg;

  // Block layout
  localparam int FRAME_BYTES = 128;
  localparam int MAX_FRAMES  = 3;
  localparam int PAL_ENTRIES = 16;

  localparam int OFF_W = 10;
  localparam logic [OFF_W-1:0] FCOUNT_LO_OFF = 10'd2;
  localparam logic [OFF_W-1:0] FCOUNT_HI_OFF = 10'd3;
  localparam logic [OFF_W-1:0] PAL_START     = 10'h060;
  localparam logic [OFF_W-1:0] PIX_START     = 10'h080;
  localparam logic [OFF_W-1:0] OFFSET_CAP    = 10'd512;
  // first offset whose arrival completes frame 0, and its base for the count
  localparam logic [OFF_W-1:0] FIRST_DONE_OFF = 10'd255;
  localparam logic [OFF_W-1:0] DONE_BASE      = 10'd127;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // floor(x * 255 / 31) for a 5-bit channel
  localparam logic [7:0] EXPAND5 [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  // Result kinds
  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // One classified byte, ready for the back end
  typedef struct packed {
    logic        has_pix;   // two pixels to emit
    logic        has_sum;   // end-of-data summary follows
    logic [15:0] word0;     // palette word for the low nibble
    logic [15:0] word1;     // palette word for the high nibble
    logic [1:0]  frame;
    logic [6:0]  pos;       // byte position within frame
    logic [1:0]  done;      // complete frames for the summary
  } entry_t;

  // One result item
  typedef struct packed {
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [1:0] frame_number;
    logic [7:0] pixel_number;
    logic [1:0] frames_complete;
    logic       last_result;
  } result_t;

  // Back-end emit phase
  typedef enum logic [2:0] {
    PH_LO  = 3'b001,
    PH_HI  = 3'b010,
    PH_SUM = 3'b100
  } phase_e;

endpackage

>>> design/ipd_fifo.sv
// Short queue of classified entries between front and back end.
// Depends on ipd_pkg.
module ipd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ipd_pkg::entry_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            not_empty_o,
  output ipd_pkg::entry_t head_o
);

  ipd_pkg::entry_t                 mem [ipd_pkg::FIFO_DEPTH];
  logic [ipd_pkg::FIFO_AW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [ipd_pkg::FIFO_AW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [ipd_pkg::FIFO_AW:0]       cnt_q, cnt_d;

  assign full_o      = (cnt_q == (ipd_pkg::FIFO_AW+1)'(ipd_pkg::FIFO_DEPTH));
  assign not_empty_o = (cnt_q != '0);
  assign head_o      = mem[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> design/ipd_front.sv
// Front end: accepts bytes, tracks the block offset, frame count and palette,
// and turns pixel bytes and the last byte into queue entries. Depends on ipd_pkg.
module ipd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      data_byte_i,
  input  logic            end_of_data_i,
  input  logic            valid_i,
  output logic            ready_o,
  output logic            push_o,
  output ipd_pkg::entry_t push_data_o,
  input  logic            full_i
);

  logic [ipd_pkg::OFF_W-1:0] offset_q, offset_d;
  logic [7:0]                fc_low_q, fc_low_d;
  logic [1:0]                wanted_q, wanted_d;
  logic [ipd_pkg::PAL_ENTRIES-1:0] lo_vld_q, lo_vld_d;
  logic [ipd_pkg::PAL_ENTRIES-1:0] hi_vld_q, hi_vld_d;
  logic                      s1_vq, s1_vd;

  // palette storage, low and high byte of each word
  logic [7:0] pal_lo_mem [ipd_pkg::PAL_ENTRIES];
  logic [7:0] pal_hi_mem [ipd_pkg::PAL_ENTRIES];

  // registered read data and entry fields
  logic [7:0] rd_lo0_q, rd_hi0_q, rd_lo1_q, rd_hi1_q;
  logic [3:0] rd_vld_q;   // {hi1, lo1, hi0, lo0}
  logic       has_pix_q, has_sum_q;
  logic [1:0] frame_q, done_q;
  logic [6:0] pos_q;

  logic                      in_fire;
  logic                      is_pal, is_pix, pix_ok;
  logic [ipd_pkg::OFF_W-1:0] rel, done_span;
  logic [3:0]                pal_idx;
  logic [3:0]                nib0, nib1;
  logic [1:0]                clamp_cnt, done_raw, done_val;

  assign ready_o = !s1_vq || !full_i;
  assign in_fire = valid_i && ready_o;
  assign push_o  = s1_vq && !full_i;

  assign nib0 = data_byte_i[3:0];
  assign nib1 = data_byte_i[7:4];

  // classify the byte by offset
  always_comb begin
    is_pal  = (offset_q >= ipd_pkg::PAL_START) && (offset_q < ipd_pkg::PIX_START);
    is_pix  = (offset_q >= ipd_pkg::PIX_START) && (offset_q < ipd_pkg::OFFSET_CAP);
    rel     = offset_q - ipd_pkg::PIX_START;
    pix_ok  = is_pix && (rel[8:7] < wanted_q);
    pal_idx = offset_q[4:1];
  end

  // frame count clamp to 1..MAX_FRAMES
  always_comb begin
    if (data_byte_i != 8'd0) begin
      clamp_cnt = 2'(ipd_pkg::MAX_FRAMES);
    end else if (fc_low_q == 8'd0) begin
      clamp_cnt = 2'd1;
    end else if (fc_low_q > 8'(ipd_pkg::MAX_FRAMES)) begin
      clamp_cnt = 2'(ipd_pkg::MAX_FRAMES);
    end else begin
      clamp_cnt = fc_low_q[1:0];
    end
  end

  // complete frames if this byte were the last
  always_comb begin
    done_span = offset_q - ipd_pkg::DONE_BASE;
    done_raw  = done_span[8:7];
    if (offset_q < ipd_pkg::FIRST_DONE_OFF) begin
      done_val = 2'd0;
    end else if (done_raw > wanted_q) begin
      done_val = wanted_q;
    end else begin
      done_val = done_raw;
    end
  end

  // state update
  always_comb begin
    offset_d = offset_q;
    fc_low_d = fc_low_q;
    wanted_d = wanted_q;
    lo_vld_d = lo_vld_q;
    hi_vld_d = hi_vld_q;
    s1_vd    = s1_vq;
    if (push_o) begin
      s1_vd = 1'b0;
    end
    if (in_fire) begin
      s1_vd = pix_ok || end_of_data_i;
      if (offset_q == ipd_pkg::FCOUNT_LO_OFF) begin
        fc_low_d = data_byte_i;
      end
      if (offset_q == ipd_pkg::FCOUNT_HI_OFF) begin
        wanted_d = clamp_cnt;
      end
      if (is_pal && !offset_q[0]) begin
        lo_vld_d[pal_idx] = 1'b1;
      end
      if (is_pal && offset_q[0]) begin
        hi_vld_d[pal_idx] = 1'b1;
      end
      if (offset_q < ipd_pkg::OFFSET_CAP) begin
        offset_d = offset_q + 1'b1;
      end
      // end of block: back to reset values
      if (end_of_data_i) begin
        offset_d = '0;
        fc_low_d = '0;
        wanted_d = 2'd1;
        lo_vld_d = '0;
        hi_vld_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      fc_low_q <= '0;
      wanted_q <= 2'd1;
      lo_vld_q <= '0;
      hi_vld_q <= '0;
      s1_vq    <= 1'b0;
    end else begin
      offset_q <= offset_d;
      fc_low_q <= fc_low_d;
      wanted_q <= wanted_d;
      lo_vld_q <= lo_vld_d;
      hi_vld_q <= hi_vld_d;
      s1_vq    <= s1_vd;
    end
  end

  // palette writes
  always_ff @(posedge clk_i) begin
    if (in_fire && is_pal && !offset_q[0]) begin
      pal_lo_mem[pal_idx] <= data_byte_i;
    end
    if (in_fire && is_pal && offset_q[0]) begin
      pal_hi_mem[pal_idx] <= data_byte_i;
    end
  end

  // palette reads and entry fields, captured with the byte
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_lo0_q  <= pal_lo_mem[nib0];
      rd_hi0_q  <= pal_hi_mem[nib0];
      rd_lo1_q  <= pal_lo_mem[nib1];
      rd_hi1_q  <= pal_hi_mem[nib1];
      rd_vld_q  <= {hi_vld_q[nib1], lo_vld_q[nib1], hi_vld_q[nib0], lo_vld_q[nib0]};
      has_pix_q <= pix_ok;
      has_sum_q <= end_of_data_i;
      frame_q   <= rel[8:7];
      pos_q     <= rel[6:0];
      done_q    <= done_val;
    end
  end

  // unwritten palette bytes read as zero
  always_comb begin
    push_data_o.has_pix = has_pix_q;
    push_data_o.has_sum = has_sum_q;
    push_data_o.word0   = {rd_vld_q[1] ? rd_hi0_q : 8'd0, rd_vld_q[0] ? rd_lo0_q : 8'd0};
    push_data_o.word1   = {rd_vld_q[3] ? rd_hi1_q : 8'd0, rd_vld_q[2] ? rd_lo1_q : 8'd0};
    push_data_o.frame   = frame_q;
    push_data_o.pos     = pos_q;
    push_data_o.done    = done_q;
  end

endmodule

>>> design/ipd_back.sv
// Back end: expands queue entries into pixel and summary results and holds
// them in the output register. Depends on ipd_pkg.
module ipd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             not_empty_i,
  input  ipd_pkg::entry_t  head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ipd_pkg::result_t out_o
);

  ipd_pkg::phase_e  phase_q, phase_d, ph;
  logic             out_vq, out_vd;
  ipd_pkg::result_t out_q, res;
  logic             out_load, entry_done;
  logic [15:0]      word;

  assign out_valid_o = out_vq;
  assign out_o       = out_q;
  assign out_load    = not_empty_i && (!out_vq || out_ready_i);
  assign pop_o       = out_load && entry_done;

  // current phase; entries without pixels go straight to the summary
  always_comb begin
    ph = phase_q;
    if ((phase_q == ipd_pkg::PH_LO) && !head_i.has_pix) begin
      ph = ipd_pkg::PH_SUM;
    end
    entry_done = (ph == ipd_pkg::PH_SUM) || ((ph == ipd_pkg::PH_HI) && !head_i.has_sum);
  end

  // build the result for this phase
  always_comb begin
    word = (ph == ipd_pkg::PH_HI) ? head_i.word1 : head_i.word0;
    res  = '0;
    case (ph)
      ipd_pkg::PH_LO, ipd_pkg::PH_HI: begin
        res.kind         = ipd_pkg::KIND_PIXEL;
        if (word != 16'd0) begin
          res.red   = ipd_pkg::EXPAND5[word[4:0]];
          res.green = ipd_pkg::EXPAND5[word[9:5]];
          res.blue  = ipd_pkg::EXPAND5[word[14:10]];
          res.alpha = 8'hFF;
        end
        res.frame_number = head_i.frame;
        res.pixel_number = {head_i.pos, (ph == ipd_pkg::PH_HI)};
      end
      ipd_pkg::PH_SUM: begin
        res.kind            = ipd_pkg::KIND_SUMMARY;
        res.frames_complete = head_i.done;
        res.last_result     = 1'b1;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // phase sequencing and output valid
  always_comb begin
    phase_d = phase_q;
    out_vd  = out_vq;
    if (out_vq && out_ready_i) begin
      out_vd = 1'b0;
    end
    if (out_load) begin
      out_vd = 1'b1;
      if (entry_done) begin
        phase_d = ipd_pkg::PH_LO;
      end else if (ph == ipd_pkg::PH_LO) begin
        phase_d = ipd_pkg::PH_HI;
      end else begin
        phase_d = ipd_pkg::PH_SUM;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ipd_pkg::PH_LO;
      out_vq  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      out_vq  <= out_vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

endmodule

>>> design/indexed_icon_pixel_decoder.sv
// Top level of the indexed icon pixel decoder.
// Depends on ipd_pkg, ipd_front, ipd_fifo and ipd_back.
//
// Streams the bytes of a save's first data block in on the slave side and
// emits RGBA8888 pixels of the 4-bit indexed icon on the master side, then
// one summary per block on the byte marked tlast (tuser high, tlast high,
// frames_complete valid). A pixel byte yields two results, sent by the back
// end at one result per cycle while the consumer is ready, so the back end
// sets the flow of pixel bytes; header, palette and ignored bytes go at one
// per cycle unless the front end stalls. A result passes the palette read
// register, queue and output register from input transfer to output valid.
// The consumer should drop pixels of frames beyond frames_complete. After the
// last byte the offset, frame count and palette flags are reset for the next block.
module indexed_icon_pixel_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // s_axis_tdata_i: [7:0] data_byte
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        s_axis_tlast_i,   // end_of_data
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // m_axis_tdata_o: [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
  // [33:32] frame_number, [41:34] pixel_number, [43:42] frames_complete,
  // [47:44] zero
  output logic [47:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o,   // kind
  output logic        m_axis_tlast_o,   // last_result
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i
);

  logic             push, full, pop, not_empty;
  ipd_pkg::entry_t  push_data, head;
  ipd_pkg::result_t res;

  ipd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (s_axis_tdata_i),
    .end_of_data_i (s_axis_tlast_i),
    .valid_i       (s_axis_tvalid_i),
    .ready_o       (s_axis_tready_o),
    .push_o        (push),
    .push_data_o   (push_data),
    .full_i        (full)
  );

  ipd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .not_empty_o (not_empty),
    .head_o      (head)
  );

  ipd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .not_empty_i (not_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (res)
  );

  // pack the result onto the master side
  assign m_axis_tdata_o = {4'd0, res.frames_complete, res.pixel_number, res.frame_number,
                           res.alpha, res.blue, res.green, res.red};
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.last_result;

endmodule

>>> design/ipd_checker.sv
// Port-level checker for the indexed icon pixel decoder, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ipd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic [47:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        m_axis_tlast_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i
);

  logic        out_stall, sum_vld, pix_vld;
  logic        sum_ok, pix_ok, alpha_ok;
  logic [49:0] out_bits;

  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign sum_vld   = m_axis_tvalid_o && m_axis_tuser_o;
  assign pix_vld   = m_axis_tvalid_o && !m_axis_tuser_o;
  assign out_bits  = {m_axis_tlast_o, m_axis_tuser_o, m_axis_tdata_o};

  // summary carries only the frame count and ends the block
  assign sum_ok   = m_axis_tlast_o && (m_axis_tdata_o[41:0] == 42'd0) &&
                    (m_axis_tdata_o[47:44] == 4'd0);
  // pixels never end the block, carry no frame count and have a frame number below 3
  assign pix_ok   = !m_axis_tlast_o && (m_axis_tdata_o[47:42] == 6'd0) &&
                    (m_axis_tdata_o[33:32] != 2'd3);
  // a pixel is opaque, or fully transparent black
  assign alpha_ok = (m_axis_tdata_o[31:24] == 8'hFF) || (m_axis_tdata_o[31:0] == 32'd0);

  // stalled result holds
  `ASSERT_CLKD(a_vld_hold, clk_i, rst_ni, out_stall |=> m_axis_tvalid_o, "valid dropped in stall")
  `ASSERT_CLKD(a_out_hold, clk_i, rst_ni, out_stall |=> $stable(out_bits), "result changed in stall")

  `ASSERT_CLKD(a_sum_shape, clk_i, rst_ni, sum_vld |-> sum_ok, "bad summary fields")
  `ASSERT_CLKD(a_pix_shape, clk_i, rst_ni, pix_vld |-> pix_ok, "bad pixel fields")
  `ASSERT_CLKD(a_pix_alpha, clk_i, rst_ni, pix_vld |-> alpha_ok, "bad pixel alpha")

endmodule

bind indexed_icon_pixel_decoder ipd_checker u_ipd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);
